[hdl/im2col_patch_gather_assert.svh]
// ----------------------------------------------------------------------------
// im2col_patch_gather assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IM2COL_PATCH_GATHER_ASSERT_SVH
`define IM2COL_PATCH_GATHER_ASSERT_SVH
`ifndef SYNTHESIS
`define IM2COL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define IM2COL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IM2COL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define IM2COL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/im2col_pkg.sv]
// ----------------------------------------------------------------------------
// im2col_pkg
// Payload types, command and register codes, and reset values of the gather.
// ----------------------------------------------------------------------------
`default_nettype none

package im2col_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] map_addr;
		logic [31:0] map_data;
	} item_t;

	typedef struct packed {
		logic [31:0] value;
		logic [13:0] col_row;
		logic [12:0] col_col;
		logic        last;
		logic        error;
	} result_t;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_FETCH   = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [2:0] REG_IN_CHANNELS   = 3'd0;
	localparam logic [2:0] REG_IN_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_IN_WIDTH      = 3'd2;
	localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd3;
	localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd4;
	localparam logic [2:0] REG_STEP_SIZE     = 3'd5;
	localparam logic [2:0] REG_PAD_SIZE      = 3'd6;

	localparam logic [8:0] RST_IN_CHANNELS   = 9'd1;
	localparam logic [6:0] RST_IN_HEIGHT     = 7'd8;
	localparam logic [6:0] RST_IN_WIDTH      = 7'd8;
	localparam logic [2:0] RST_KERNEL_HEIGHT = 3'd3;
	localparam logic [2:0] RST_KERNEL_WIDTH  = 3'd3;
	localparam logic [2:0] RST_STEP_SIZE     = 3'd1;
	localparam logic [1:0] RST_PAD_SIZE      = 2'd1;

	localparam int RST_OUT_H = (int'(RST_IN_HEIGHT) + 2 * int'(RST_PAD_SIZE)
		- int'(RST_KERNEL_HEIGHT)) / int'(RST_STEP_SIZE) + 1;
	localparam int RST_OUT_W = (int'(RST_IN_WIDTH) + 2 * int'(RST_PAD_SIZE)
		- int'(RST_KERNEL_WIDTH)) / int'(RST_STEP_SIZE) + 1;
	localparam int RST_VOLUME = int'(RST_IN_CHANNELS) * int'(RST_IN_HEIGHT)
		* int'(RST_IN_WIDTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_AREA,
		ST_VOLUME,
		ST_CHECK,
		ST_IDX,
		ST_TAP,
		ST_ADDR,
		ST_READ,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

[hdl/im2col_patch_gather.sv]
// ----------------------------------------------------------------------------
// im2col_patch_gather
// Column-matrix gather over a channel-major feature map held in a word RAM.
// ----------------------------------------------------------------------------
// Input channel: an item is taken on a rising edge with start high and busy
// low. A write item stores map_data at map_addr, a restart item sends the
// walk back to its first element; both finish in the cycle they are taken.
// A fetch item returns one column-matrix element: done pulses for one cycle
// with the result after the capture, index, tap, address and read registers.
// busy drops again in the cycle of done, so one fetch ends before the next is
// taken; the path is a chain of index multiplies, tap-address multiply and the
// single RAM read. Writes and restarts run at one per cycle while busy is low.
// Configuration: APB registers at byte offsets 4*i. Each write starts a
// geometry recompute (output height and width come from an iterative
// divider that produces one quotient bit per cycle, then the map volume
// check); busy stays high until it completes.
// Reset clears the walk and loads the default geometry; the map RAM is not
// cleared. Results cannot be held off: done and result are valid for one
// cycle only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "im2col_patch_gather_assert.svh"

module im2col_patch_gather #(
	parameter int MAP_WORDS = 4096,
	parameter int WORD_BITS = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  im2col_pkg::item_t      item,
	output logic                   done,
	output im2col_pkg::result_t    result,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [4:0]             paddr,
	input  wire  [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import im2col_pkg::*;

	localparam int AW = $clog2(MAP_WORDS);
	localparam logic RST_CFG_OK = (RST_VOLUME <= MAP_WORDS);

	// configuration
	logic [8:0] in_channels_q;
	logic [6:0] in_height_q;
	logic [6:0] in_width_q;
	logic [2:0] kernel_height_q;
	logic [2:0] kernel_width_q;
	logic [2:0] step_size_q;
	logic [1:0] pad_size_q;
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	// derived geometry
	logic [6:0]  out_h_q;
	logic [6:0]  out_w_q;
	logic        cfg_ok_q;
	logic [7:0]  hpad;
	logic [7:0]  wpad;
	logic [7:0]  num_h_q;
	logic [7:0]  num_w_q;
	logic [2:0]  rem_h_q;
	logic [2:0]  rem_w_q;
	logic [2:0]  div_cnt_q;
	logic [13:0] hw_q;
	logic [22:0] chw_q;

	// control
	state_t state_q;
	state_t state_d;
	logic   can_take;
	logic   acc;
	logic   fetch_acc;

	// walk counters
	logic [7:0] ch_q;
	logic [2:0] ky_q;
	logic [2:0] kx_q;
	logic [6:0] or_q;
	logic [6:0] oc_q;
	logic       cnt_oob;
	logic [7:0] e_ch;
	logic [2:0] e_ky;
	logic [2:0] e_kx;
	logic [6:0] e_or;
	logic [6:0] e_oc;
	logic [8:0] ch_inc;
	logic [3:0] ky_inc;
	logic [3:0] kx_inc;
	logic [7:0] or_inc;
	logic [7:0] oc_inc;
	logic       walk_last;
	logic [7:0] n_ch;
	logic [2:0] n_ky;
	logic [2:0] n_kx;
	logic [6:0] n_or;
	logic [6:0] n_oc;

	// fetch pipeline
	logic [7:0]  ch_s1;
	logic [2:0]  ky_s1;
	logic [2:0]  kx_s1;
	logic [6:0]  or_s1;
	logic [6:0]  oc_s1;
	logic        err_s1;
	logic        last_s1;
	logic [9:0]  ors_s2;
	logic [9:0]  ocs_s2;
	logic [14:0] ch_h_s2;
	logic [10:0] ch_kh_s2;
	logic [13:0] or_ow_s2;
	logic [2:0]  ky_s2;
	logic [2:0]  kx_s2;
	logic [6:0]  oc_s2;
	logic        err_s2;
	logic        last_s2;
	logic [9:0]  py;
	logic [9:0]  px;
	logic [9:0]  iy;
	logic [9:0]  ix;
	logic        tap_in;
	logic [10:0] kidx;
	logic [15:0] row_a_s3;
	logic [9:0]  ix_s3;
	logic        tap_s3;
	logic [13:0] rp_s3;
	logic [2:0]  kx_s3;
	logic [12:0] col_s3;
	logic        err_s3;
	logic        last_s3;
	logic [22:0] addr_s4;
	logic        tap_s4;
	logic [13:0] row_s4;
	logic [12:0] col_s4;
	logic        err_s4;
	logic        last_s4;
	logic        addr_ok;
	logic        rd_en;
	logic [AW-1:0] rd_idx;
	logic [WORD_BITS-1:0] rd_word_s5;
	logic        zero_s5;
	logic [13:0] row_s5;
	logic [12:0] col_s5;
	logic        err_s5;
	logic        last_s5;

	// map RAM
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic                 mem_we;
	logic [AW-1:0]        wr_idx;
	logic [WORD_BITS-1:0] wr_word;

	// one restoring-division step: returns {shifted numerator with quotient bit, remainder}
	function automatic logic [10:0] div_step(input logic [7:0] num, input logic [2:0] rem,
			input logic [2:0] dvs);
		logic [3:0] part;
		part = {rem, num[7]};
		if (part >= {1'b0, dvs}) begin
			return {num[6:0], 1'b1, 3'(part - {1'b0, dvs})};
		end else begin
			return {num[6:0], 1'b0, part[2:0]};
		end
	endfunction

	// ---------------- configuration port ----------------
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_comb begin
		unique case (cfg_idx)
			REG_IN_CHANNELS:   prdata = 32'(in_channels_q);
			REG_IN_HEIGHT:     prdata = 32'(in_height_q);
			REG_IN_WIDTH:      prdata = 32'(in_width_q);
			REG_KERNEL_HEIGHT: prdata = 32'(kernel_height_q);
			REG_KERNEL_WIDTH:  prdata = 32'(kernel_width_q);
			REG_STEP_SIZE:     prdata = 32'(step_size_q);
			REG_PAD_SIZE:      prdata = 32'(pad_size_q);
			default:           prdata = '0;
		endcase
	end

	assign hpad = {1'b0, in_height_q} + {5'b0, pad_size_q, 1'b0};
	assign wpad = {1'b0, in_width_q} + {5'b0, pad_size_q, 1'b0};

	// ---------------- handshake and sequencer ----------------
	assign can_take  = (state_q == ST_IDLE) || (state_q == ST_OUT);
	assign busy      = !can_take || cfg_wr;
	assign acc       = start && !busy;
	assign fetch_acc = acc && (item.cmd == CMD_FETCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_OUT: begin
				priority if (cfg_wr) state_d = ST_LOAD;
				else if (fetch_acc) state_d = ST_IDX;
				else state_d = ST_IDLE;
			end
			ST_LOAD:   state_d = cfg_wr ? ST_LOAD : ST_DIV;
			ST_DIV: begin
				priority if (cfg_wr) state_d = ST_LOAD;
				else if (div_cnt_q == 3'd7) state_d = ST_AREA;
				else state_d = ST_DIV;
			end
			ST_AREA:   state_d = cfg_wr ? ST_LOAD : ST_VOLUME;
			ST_VOLUME: state_d = cfg_wr ? ST_LOAD : ST_CHECK;
			ST_CHECK:  state_d = cfg_wr ? ST_LOAD : ST_IDLE;
			ST_IDX:    state_d = ST_TAP;
			ST_TAP:    state_d = ST_ADDR;
			ST_ADDR:   state_d = ST_READ;
			ST_READ:   state_d = ST_OUT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ---------------- walk counters ----------------
	always_comb begin
		cnt_oob = ({1'b0, ch_q} >= in_channels_q) || (ky_q >= kernel_height_q)
			|| (kx_q >= kernel_width_q) || (or_q >= out_h_q) || (oc_q >= out_w_q);
		// restart the walk if a geometry change left it out of bounds
		e_ch = cnt_oob ? '0 : ch_q;
		e_ky = cnt_oob ? '0 : ky_q;
		e_kx = cnt_oob ? '0 : kx_q;
		e_or = cnt_oob ? '0 : or_q;
		e_oc = cnt_oob ? '0 : oc_q;
		ch_inc = {1'b0, e_ch} + 9'd1;
		ky_inc = {1'b0, e_ky} + 4'd1;
		kx_inc = {1'b0, e_kx} + 4'd1;
		or_inc = {1'b0, e_or} + 8'd1;
		oc_inc = {1'b0, e_oc} + 8'd1;
		walk_last = (ch_inc == in_channels_q) && (ky_inc == {1'b0, kernel_height_q})
			&& (kx_inc == {1'b0, kernel_width_q}) && (or_inc == {1'b0, out_h_q})
			&& (oc_inc == {1'b0, out_w_q});
		n_ch = e_ch;
		n_ky = e_ky;
		n_kx = e_kx;
		n_or = e_or;
		n_oc = e_oc;
		priority if (walk_last) begin
			n_ch = '0;
			n_ky = '0;
			n_kx = '0;
			n_or = '0;
			n_oc = '0;
		end else if (oc_inc < {1'b0, out_w_q}) begin
			n_oc = oc_inc[6:0];
		end else begin
			n_oc = '0;
			priority if (or_inc < {1'b0, out_h_q}) begin
				n_or = or_inc[6:0];
			end else begin
				n_or = '0;
				priority if (kx_inc < {1'b0, kernel_width_q}) begin
					n_kx = kx_inc[2:0];
				end else begin
					n_kx = '0;
					priority if (ky_inc < {1'b0, kernel_height_q}) begin
						n_ky = ky_inc[2:0];
					end else begin
						n_ky = '0;
						n_ch = (ch_inc < in_channels_q) ? ch_inc[7:0] : '0;
					end
				end
			end
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q   <= RST_IN_CHANNELS;
			in_height_q     <= RST_IN_HEIGHT;
			in_width_q      <= RST_IN_WIDTH;
			kernel_height_q <= RST_KERNEL_HEIGHT;
			kernel_width_q  <= RST_KERNEL_WIDTH;
			step_size_q     <= RST_STEP_SIZE;
			pad_size_q      <= RST_PAD_SIZE;
			out_h_q         <= 7'(RST_OUT_H);
			out_w_q         <= 7'(RST_OUT_W);
			cfg_ok_q        <= RST_CFG_OK;
			div_cnt_q       <= '0;
			ch_q            <= '0;
			ky_q            <= '0;
			kx_q            <= '0;
			or_q            <= '0;
			oc_q            <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_IN_CHANNELS:   in_channels_q   <= pwdata[8:0];
					REG_IN_HEIGHT:     in_height_q     <= pwdata[6:0];
					REG_IN_WIDTH:      in_width_q      <= pwdata[6:0];
					REG_KERNEL_HEIGHT: kernel_height_q <= pwdata[2:0];
					REG_KERNEL_WIDTH:  kernel_width_q  <= pwdata[2:0];
					REG_STEP_SIZE:     step_size_q     <= pwdata[2:0];
					REG_PAD_SIZE:      pad_size_q      <= pwdata[1:0];
					default: ;
				endcase
			end
			if (state_q == ST_LOAD) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 3'd1;
			end
			if (state_q == ST_AREA) begin
				out_h_q <= 7'(num_h_q + 8'd1);
				out_w_q <= 7'(num_w_q + 8'd1);
			end
			if (state_q == ST_CHECK) begin
				cfg_ok_q <= (in_channels_q != '0) && (in_channels_q <= 9'd256)
					&& (in_height_q != '0) && (in_height_q <= 7'd64)
					&& (in_width_q != '0) && (in_width_q <= 7'd64)
					&& (kernel_height_q != '0) && (kernel_width_q != '0)
					&& (step_size_q != '0)
					&& ({5'b0, kernel_height_q} <= hpad)
					&& ({5'b0, kernel_width_q} <= wpad)
					&& (32'(chw_q) <= 32'(MAP_WORDS));
			end
			if (acc && (item.cmd == CMD_RESTART)) begin
				ch_q <= '0;
				ky_q <= '0;
				kx_q <= '0;
				or_q <= '0;
				oc_q <= '0;
			end else if (fetch_acc && cfg_ok_q) begin
				ch_q <= n_ch;
				ky_q <= n_ky;
				kx_q <= n_kx;
				or_q <= n_or;
				oc_q <= n_oc;
			end
		end
	end

	// ---------------- geometry datapath ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			num_h_q <= hpad - {5'b0, kernel_height_q};
			num_w_q <= wpad - {5'b0, kernel_width_q};
			rem_h_q <= '0;
			rem_w_q <= '0;
		end else if (state_q == ST_DIV) begin
			{num_h_q, rem_h_q} <= div_step(num_h_q, rem_h_q, step_size_q);
			{num_w_q, rem_w_q} <= div_step(num_w_q, rem_w_q, step_size_q);
		end
		hw_q  <= 14'(in_height_q) * 14'(in_width_q);
		chw_q <= 23'(in_channels_q) * 23'(hw_q);
	end

	// ---------------- fetch pipeline ----------------
	always_comb begin
		py     = ors_s2 + 10'(ky_s2);
		px     = ocs_s2 + 10'(kx_s2);
		iy     = py - 10'(pad_size_q);
		ix     = px - 10'(pad_size_q);
		tap_in = (py >= 10'(pad_size_q)) && (px >= 10'(pad_size_q))
			&& (iy < 10'(in_height_q)) && (ix < 10'(in_width_q));
		kidx   = ch_kh_s2 + 11'(ky_s2);
	end

	assign addr_ok = (32'(addr_s4) < 32'(MAP_WORDS));
	assign rd_en   = (state_q == ST_READ) && tap_s4 && addr_ok && !err_s4;
	assign rd_idx  = AW'(addr_s4);

	always_ff @(posedge clk) begin
		if (fetch_acc) begin
			ch_s1   <= e_ch;
			ky_s1   <= e_ky;
			kx_s1   <= e_kx;
			or_s1   <= e_or;
			oc_s1   <= e_oc;
			err_s1  <= !cfg_ok_q;
			last_s1 <= walk_last && cfg_ok_q;
		end
		// index products
		ors_s2   <= 10'(or_s1) * 10'(step_size_q);
		ocs_s2   <= 10'(oc_s1) * 10'(step_size_q);
		ch_h_s2  <= 15'(ch_s1) * 15'(in_height_q);
		ch_kh_s2 <= 11'(ch_s1) * 11'(kernel_height_q);
		or_ow_s2 <= 14'(or_s1) * 14'(out_w_q);
		ky_s2    <= ky_s1;
		kx_s2    <= kx_s1;
		oc_s2    <= oc_s1;
		err_s2   <= err_s1;
		last_s2  <= last_s1;
		// tap position and padding
		row_a_s3 <= 16'(ch_h_s2) + 16'(iy);
		ix_s3    <= ix;
		tap_s3   <= tap_in;
		rp_s3    <= 14'(kidx) * 14'(kernel_width_q);
		kx_s3    <= kx_s2;
		col_s3   <= 13'(or_ow_s2 + 14'(oc_s2));
		err_s3   <= err_s2;
		last_s3  <= last_s2;
		// tap address
		addr_s4  <= 23'(row_a_s3) * 23'(in_width_q) + 23'(ix_s3);
		tap_s4   <= tap_s3;
		row_s4   <= rp_s3 + 14'(kx_s3);
		col_s4   <= col_s3;
		err_s4   <= err_s3;
		last_s4  <= last_s3;
		// RAM read
		zero_s5  <= !(tap_s4 && addr_ok) || err_s4;
		row_s5   <= row_s4;
		col_s5   <= col_s4;
		err_s5   <= err_s4;
		last_s5  <= last_s4;
	end

	// ---------------- map RAM ----------------
	assign mem_we  = acc && (item.cmd == CMD_WRITE) && (32'(item.map_addr) < 32'(MAP_WORDS));
	assign wr_idx  = AW'(item.map_addr);
	assign wr_word = WORD_BITS'(item.map_data);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[wr_idx] <= wr_word;
		end
		if (rd_en) begin
			rd_word_s5 <= map_mem[rd_idx];
		end
	end

	// ---------------- result ----------------
	assign done = (state_q == ST_OUT);

	always_comb begin
		result.value   = zero_s5 ? '0 : 32'(rd_word_s5);
		result.col_row = err_s5 ? '0 : row_s5;
		result.col_col = err_s5 ? '0 : col_s5;
		result.last    = err_s5 ? 1'b0 : last_s5;
		result.error   = err_s5;
	end

	// ---------------- assertions ----------------
	`IM2COL_ASSERT_IMPLIES(a_fetch_latency, clk, arst_n, done, $past(fetch_acc, 5),
		"result strobe without a fetch transaction five cycles earlier")
	`IM2COL_ASSERT_IMPLIES(a_error_zero, clk, arst_n, done && result.error,
		result.value == '0 && result.col_row == '0 && result.col_col == '0 && !result.last,
		"error result carries nonzero payload")
	`IM2COL_ASSERT_IMPLIES(a_last_wraps, clk, arst_n, done && result.last,
		ch_q == '0 && ky_q == '0 && kx_q == '0 && or_q == '0 && oc_q == '0,
		"walk did not wrap after the last element")

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// im2col_patch_gather testbench
// Preloads the low map store words that every geometry reads, then runs a
// short directed sequence and a series of geometry phases with random write,
// fetch, restart and ignored transactions under random start gaps. A
// column-walk tracker predicts every fetched element and checks each done
// strobe field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import im2col_pkg::*;

	localparam int STORE_WORDS   = 4096;
	localparam int PRELOAD_WORDS = 256;
	localparam int RANDOM_ITEMS  = 1380;
	localparam int PHASES        = 20;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int MAX_REPORTS   = 40;
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	// Tracks geometry, walk position and store contents; predicts each fetch.
	class column_walk_tracker;
		int unsigned geom [7];
		int unsigned ch_pos, ky_pos, kx_pos, oy_pos, ox_pos;
		logic [31:0] map_mem [STORE_WORDS];
		result_t     awaited_elements [$];
		int          mismatches;

		function new();
			geom[REG_IN_CHANNELS]   = RST_IN_CHANNELS;
			geom[REG_IN_HEIGHT]     = RST_IN_HEIGHT;
			geom[REG_IN_WIDTH]      = RST_IN_WIDTH;
			geom[REG_KERNEL_HEIGHT] = RST_KERNEL_HEIGHT;
			geom[REG_KERNEL_WIDTH]  = RST_KERNEL_WIDTH;
			geom[REG_STEP_SIZE]     = RST_STEP_SIZE;
			geom[REG_PAD_SIZE]      = RST_PAD_SIZE;
			mismatches = 0;
			clear_walk();
		endfunction

		function int unsigned field_mask(logic [2:0] idx);
			case (idx)
				REG_IN_CHANNELS: return 32'h1FF;
				REG_IN_HEIGHT, REG_IN_WIDTH: return 32'h7F;
				REG_PAD_SIZE: return 32'h3;
				default: return 32'h7;
			endcase
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			geom[idx] = data & field_mask(idx);
		endfunction

		function void clear_walk();
			ch_pos = 0;
			ky_pos = 0;
			kx_pos = 0;
			oy_pos = 0;
			ox_pos = 0;
		endfunction

		function bit geometry_valid();
			int unsigned ch, ih, iw, kh, kw, st, pd;
			ch = geom[REG_IN_CHANNELS];
			ih = geom[REG_IN_HEIGHT];
			iw = geom[REG_IN_WIDTH];
			kh = geom[REG_KERNEL_HEIGHT];
			kw = geom[REG_KERNEL_WIDTH];
			st = geom[REG_STEP_SIZE];
			pd = geom[REG_PAD_SIZE];
			if (ch == 0 || ch > 256 || ih == 0 || ih > 64 || iw == 0 || iw > 64)
				return 0;
			if (kh == 0 || kw == 0 || st == 0)
				return 0;
			if (kh > ih + 2 * pd || kw > iw + 2 * pd)
				return 0;
			return ch * ih * iw <= STORE_WORDS;
		endfunction

		function result_t gather_element();
			result_t     r;
			int unsigned ch, ih, iw, kh, kw, st, pd, oh, ow, py, px, addr;
			r = '0;
			if (!geometry_valid()) begin
				r.error = 1'b1;
				return r;
			end
			ch = geom[REG_IN_CHANNELS];
			ih = geom[REG_IN_HEIGHT];
			iw = geom[REG_IN_WIDTH];
			kh = geom[REG_KERNEL_HEIGHT];
			kw = geom[REG_KERNEL_WIDTH];
			st = geom[REG_STEP_SIZE];
			pd = geom[REG_PAD_SIZE];
			oh = (ih + 2 * pd - kh) / st + 1;
			ow = (iw + 2 * pd - kw) / st + 1;
			// a geometry change may strand the walk outside the new bounds
			if (ch_pos >= ch || ky_pos >= kh || kx_pos >= kw || oy_pos >= oh || ox_pos >= ow)
				clear_walk();
			py = oy_pos * st + ky_pos;
			px = ox_pos * st + kx_pos;
			if (py >= pd && px >= pd && py - pd < ih && px - pd < iw) begin
				addr = (ch_pos * ih + py - pd) * iw + px - pd;
				if (addr < STORE_WORDS)
					r.value = map_mem[addr];
			end
			r.col_row = 14'((ch_pos * kh + ky_pos) * kw + kx_pos);
			r.col_col = 13'(oy_pos * ow + ox_pos);
			r.last = (ch_pos + 1 == ch) && (ky_pos + 1 == kh) && (kx_pos + 1 == kw)
				&& (oy_pos + 1 == oh) && (ox_pos + 1 == ow);
			if (r.last) begin
				clear_walk();
			end else begin
				ox_pos++;
				if (ox_pos >= ow) begin
					ox_pos = 0;
					oy_pos++;
					if (oy_pos >= oh) begin
						oy_pos = 0;
						kx_pos++;
						if (kx_pos >= kw) begin
							kx_pos = 0;
							ky_pos++;
							if (ky_pos >= kh) begin
								ky_pos = 0;
								ch_pos++;
								if (ch_pos >= ch)
									ch_pos = 0;
							end
						end
					end
				end
			end
			return r;
		endfunction

		function void take_item(item_t it);
			case (it.cmd)
				CMD_WRITE: map_mem[it.map_addr] = it.map_data;
				CMD_RESTART: clear_walk();
				CMD_FETCH: awaited_elements.push_back(gather_element());
				default: ;
			endcase
		endfunction

		function void flag_field(string field, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		endfunction

		function void check_element(result_t got);
			result_t want;
			if (awaited_elements.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = awaited_elements.pop_front();
			if (got.value !== want.value)
				flag_field("value", want.value, got.value);
			if (got.col_row !== want.col_row)
				flag_field("col_row", want.col_row, got.col_row);
			if (got.col_col !== want.col_col)
				flag_field("col_col", want.col_col, got.col_col);
			if (got.last !== want.last)
				flag_field("last", want.last, got.last);
			if (got.error !== want.error)
				flag_field("error", want.error, got.error);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	column_walk_tracker tracker;
	int                 cycle_count;
	bit                 steady;

	// chans, height, width, kernel h, kernel w, stride, pad
	int unsigned corner_cfgs [8][7] = '{
		'{256, 1, 1, 7, 7, 4, 3},
		'{1, 64, 4, 1, 1, 1, 3},
		'{2, 1, 1, 7, 7, 1, 3},
		'{511, 127, 127, 7, 7, 7, 3},
		'{1, 4, 64, 7, 7, 4, 3},
		'{1, 1, 1, 1, 1, 0, 0},
		'{1, 2, 2, 7, 7, 1, 2},
		'{17, 16, 16, 3, 3, 2, 1}
	};

	im2col_patch_gather uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_element(result);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic item_t make_item(logic [1:0] c, logic [11:0] a, logic [31:0] d);
		item_t it;
		it.cmd = c;
		it.map_addr = a;
		it.map_data = d;
		return it;
	endfunction

	function automatic item_t random_item();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			return make_item(CMD_FETCH, 12'($urandom), $urandom);
		else if (pick < 87)
			return make_item(CMD_WRITE, 12'($urandom), $urandom);
		else if (pick < 94)
			return make_item(CMD_RESTART, 12'($urandom), $urandom);
		return make_item(CMD_IGNORED, 12'($urandom), $urandom);
	endfunction

	function automatic int pick_gap();
		int unsigned pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Call at a rising edge; returns at the edge that accepts the transaction.
	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		tracker.take_item(it);
	endtask

	task automatic apb_write(input logic [2:0] idx, input int unsigned val);
		logic [31:0] noise;
		noise = $urandom_range(0, 1) ? $urandom : 32'h0;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= (noise & ~tracker.field_mask(idx)) | (val & tracker.field_mask(idx));
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_reg(idx, val);
		// hold off until the geometry recompute has finished
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_geometry(input int unsigned g [7]);
		start <= 1'b0;
		while (tracker.awaited_elements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int ri = 0; ri < 7; ri++)
			apb_write(3'(ri), g[ri]);
	endtask

	function automatic void random_geometry(output int unsigned g [7]);
		if ($urandom_range(0, 4) == 0) begin
			g[REG_IN_CHANNELS] = $urandom_range(0, 511);
			g[REG_IN_HEIGHT] = $urandom_range(0, 127);
			g[REG_IN_WIDTH] = $urandom_range(0, 127);
			g[REG_KERNEL_HEIGHT] = $urandom_range(0, 7);
			g[REG_KERNEL_WIDTH] = $urandom_range(0, 7);
			g[REG_STEP_SIZE] = $urandom_range(0, 7);
			g[REG_PAD_SIZE] = $urandom_range(0, 3);
			// keep any map that fits the store inside the preloaded words
			if (g[REG_IN_CHANNELS] * g[REG_IN_HEIGHT] * g[REG_IN_WIDTH] <= STORE_WORDS
				&& g[REG_IN_CHANNELS] * g[REG_IN_HEIGHT] * g[REG_IN_WIDTH] > PRELOAD_WORDS)
				g[REG_IN_CHANNELS] = 257;
			return;
		end
		// small valid geometry so that the walk wraps often
		g[REG_IN_CHANNELS] = $urandom_range(1, 3);
		g[REG_IN_HEIGHT] = $urandom_range(1, 8);
		g[REG_IN_WIDTH] = $urandom_range(1, 8);
		g[REG_PAD_SIZE] = $urandom_range(0, 3);
		g[REG_KERNEL_HEIGHT] = $urandom_range(1,
			(g[REG_IN_HEIGHT] + 2 * g[REG_PAD_SIZE] < 7) ?
			g[REG_IN_HEIGHT] + 2 * g[REG_PAD_SIZE] : 7);
		g[REG_KERNEL_WIDTH] = $urandom_range(1,
			(g[REG_IN_WIDTH] + 2 * g[REG_PAD_SIZE] < 7) ?
			g[REG_IN_WIDTH] + 2 * g[REG_PAD_SIZE] : 7);
		g[REG_STEP_SIZE] = $urandom_range(1, 4);
	endfunction

	initial begin
		int unsigned g [7];
		int unsigned single_tap [7];
		int unsigned no_channels [7];
		single_tap = '{1, 1, 1, 1, 1, 1, 0};
		no_channels = '{0, 8, 8, 3, 3, 1, 1};
		tracker = new();
		cycle_count <= 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		steady = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the low store words so that no fetch reads an unwritten one
		for (int a = 0; a < PRELOAD_WORDS; a++)
			send_item(make_item(CMD_WRITE, 12'(a), $urandom));

		// default geometry: walk starts in the top-left padding
		send_item(make_item(CMD_FETCH, 12'h000, 32'h0));
		send_item(make_item(CMD_FETCH, 12'hFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_WRITE, 12'hFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_WRITE, 12'h000, 32'h0000_0000));
		send_item(make_item(CMD_IGNORED, 12'hFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_RESTART, 12'hFFF, 32'hFFFF_FFFF));
		repeat (12) send_item(make_item(CMD_FETCH, 12'h000, 32'h0));

		// one-element walk flags last every time and wraps
		load_geometry(single_tap);
		repeat (3) send_item(make_item(CMD_FETCH, 12'h000, 32'h0));

		load_geometry(no_channels);
		repeat (2) send_item(make_item(CMD_FETCH, 12'h000, 32'h0));

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 8)
				g = corner_cfgs[ph];
			else
				random_geometry(g);
			load_geometry(g);
			steady = ($urandom_range(0, 3) == 0);
			repeat (RANDOM_ITEMS / PHASES) send_item(random_item());
		end

		start <= 1'b0;
		while (tracker.awaited_elements.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

[files.f]
+incdir+hdl
hdl/im2col_pkg.sv
hdl/im2col_patch_gather.sv
verif/testbench.sv
